@@ rtl/page_mapped_flash_translation_defines.svh @@
// ----------------------------------------------------------------------------
// page_mapped_flash_translation_defines
// Assertion macros shared by the checker of the flash translation block.
// ----------------------------------------------------------------------------
`ifndef PAGE_MAPPED_FLASH_TRANSLATION_DEFINES_SVH
`define PAGE_MAPPED_FLASH_TRANSLATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pmft_pkg.sv @@
// ----------------------------------------------------------------------------
// pmft_pkg
// Geometry, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pmft_pkg;

  localparam int PAGES_PER_BLK = 8;
  localparam int DATA_BLKS     = 16;
  localparam int TOTAL_BLKS    = 17;
  localparam int LOG_PAGES     = DATA_BLKS * PAGES_PER_BLK;

  localparam int LSN_W  = 7;
  localparam int PAGE_W = 8;
  localparam int BLK_W  = 5;
  localparam int CMD_W  = 3;
  localparam int OFF_W  = $clog2(PAGES_PER_BLK);
  localparam int IDX_W  = $clog2(LOG_PAGES);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [CMD_W-1:0] CMD_EMPTY    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COPY     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PROGRAM  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CAPACITY = 3'd5;

  // Which result the datapath is to form this cycle.
  localparam logic [2:0] EMIT_NONE   = 3'd0;
  localparam logic [2:0] EMIT_LOOKUP = 3'd1;
  localparam logic [2:0] EMIT_FRESH  = 3'd2;
  localparam logic [2:0] EMIT_CAP    = 3'd3;
  localparam logic [2:0] EMIT_COPY   = 3'd4;
  localparam logic [2:0] EMIT_ERASE  = 3'd5;
  localparam logic [2:0] EMIT_FINAL  = 3'd6;

  typedef struct packed {
    logic       accept;
    logic [2:0] emit;
    logic       push;
    logic       load_victim;
    logic       i_inc;
    logic       scan_clr;
    logic       scan_step;
  } ctl_t;

  typedef struct packed {
    logic op;
    logic fresh_left;
    logic fifo_empty_after;
    logic i_done;
    logic i_victim;
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

@@ rtl/pmft_ram.sv @@
// ----------------------------------------------------------------------------
// pmft_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pmft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pmft_dp.sv @@
// ----------------------------------------------------------------------------
// pmft_dp
// Datapath: map and invalid-page memories, counters, reverse scan, results.
// ----------------------------------------------------------------------------
module pmft_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  pmft_pkg::ctl_t               ctl,
  output pmft_pkg::sts_t               sts,
  input  logic                         operation,
  input  logic [pmft_pkg::LSN_W-1:0]   lsn,
  output logic [pmft_pkg::CMD_W-1:0]   command,
  output logic [pmft_pkg::PAGE_W-1:0]  src_page,
  output logic [pmft_pkg::PAGE_W-1:0]  dst_page,
  output logic [pmft_pkg::BLK_W-1:0]   erase_block,
  output logic [pmft_pkg::LSN_W-1:0]   spare_tag,
  output logic                         last
);

  localparam int PW = pmft_pkg::PAGE_W;
  localparam int OW = pmft_pkg::OFF_W;
  localparam int IW = pmft_pkg::IDX_W;
  localparam int CW = pmft_pkg::CNT_W;

  logic                   op;
  logic [IW-1:0]          lpn;
  logic [CW-1:0]          fresh;
  logic [IW-1:0]          head;
  logic [CW-1:0]          count;
  logic [pmft_pkg::BLK_W-1:0] spare;
  logic [PW-1:0]          victim;
  logic [OW:0]            i;
  logic [CW-1:0]          j;
  logic [IW-1:0]          jd;
  logic                   pend;
  logic [pmft_pkg::LOG_PAGES-1:0] mvalid;

  logic                   map_we;
  logic [IW-1:0]          map_waddr;
  logic [PW-1:0]          map_wdata;
  logic [IW-1:0]          map_raddr;
  logic [PW-1:0]          map_rdata;
  logic                   push_ok;
  logic [PW-1:0]          fifo_rdata;
  logic [PW-1:0]          copy_src;
  logic [PW-1:0]          copy_dst;
  logic [PW-1:0]          fresh_page;
  logic [PW-1:0]          final_page;
  logic                   hit;

  assign copy_src   = {victim[PW-1:OW], i[OW-1:0]};
  assign copy_dst   = {spare, i[OW-1:0]};
  assign final_page = {spare, victim[OW-1:0]};
  assign fresh_page = PW'(pmft_pkg::LOG_PAGES - 1) - PW'(fresh);
  assign hit        = pend && mvalid[jd] && (map_rdata == copy_src);
  assign push_ok    = ctl.push && mvalid[lpn] && (count < CW'(pmft_pkg::LOG_PAGES));

  assign sts.op               = op;
  assign sts.fresh_left       = (fresh < CW'(pmft_pkg::LOG_PAGES));
  assign sts.fifo_empty_after = (count == '0) && !mvalid[lpn];
  assign sts.i_done           = (i == (OW+1)'(pmft_pkg::PAGES_PER_BLK));
  assign sts.i_victim         = (copy_src == victim);
  assign sts.scan_hit         = hit;
  assign sts.scan_end         = (j == CW'(pmft_pkg::LOG_PAGES)) && !hit;

  always_comb begin
    map_raddr = ctl.accept ? IW'(lsn) : j[IW-1:0];
    map_we    = 1'b0;
    map_waddr = lpn;
    map_wdata = fresh_page;
    if (ctl.emit == pmft_pkg::EMIT_FRESH) begin
      map_we = 1'b1;
    end else if (ctl.emit == pmft_pkg::EMIT_FINAL) begin
      map_we    = 1'b1;
      map_wdata = final_page;
    end else if (ctl.scan_step && hit) begin
      map_we    = 1'b1;
      map_waddr = jd;
      map_wdata = copy_dst;
    end
  end

  pmft_ram #(.WIDTH(PW), .DEPTH(pmft_pkg::LOG_PAGES)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // The invalid-page ring is always read at its head.
  pmft_ram #(.WIDTH(PW), .DEPTH(pmft_pkg::LOG_PAGES)) u_fifo (
    .clk(clk), .we(push_ok), .waddr(head + count[IW-1:0]), .wdata(map_rdata),
    .raddr(head), .rdata(fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh  <= '0;
      head   <= '0;
      count  <= '0;
      spare  <= pmft_pkg::BLK_W'(pmft_pkg::TOTAL_BLKS - 1);
      mvalid <= '0;
      pend   <= 1'b0;
    end else begin
      if (push_ok) begin
        count <= count + 1'b1;
      end
      if (ctl.emit == pmft_pkg::EMIT_FRESH) begin
        fresh       <= fresh + 1'b1;
        mvalid[lpn] <= 1'b1;
      end
      if (ctl.emit == pmft_pkg::EMIT_FINAL) begin
        mvalid[lpn] <= 1'b1;
        head        <= head + 1'b1;
        count       <= count - 1'b1;
        spare       <= victim[PW-1:OW];
      end
      if (ctl.scan_clr) begin
        pend <= 1'b0;
      end else if (ctl.scan_step) begin
        pend <= (j != CW'(pmft_pkg::LOG_PAGES));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op  <= operation;
      lpn <= IW'(lsn);
    end
    if (ctl.load_victim) begin
      victim <= fifo_rdata;
      i      <= '0;
    end else if (ctl.i_inc) begin
      i <= i + 1'b1;
    end
    if (ctl.scan_clr) begin
      j <= '0;
    end else if (ctl.scan_step && (j != CW'(pmft_pkg::LOG_PAGES))) begin
      j  <= j + 1'b1;
      jd <= j[IW-1:0];
    end
    if (ctl.emit != pmft_pkg::EMIT_NONE) begin
      command     <= pmft_pkg::CMD_PROGRAM;
      src_page    <= '0;
      dst_page    <= '0;
      erase_block <= '0;
      spare_tag   <= '0;
      last        <= 1'b1;
      case (ctl.emit)
        pmft_pkg::EMIT_LOOKUP: begin
          command  <= mvalid[lpn] ? pmft_pkg::CMD_READ : pmft_pkg::CMD_EMPTY;
          src_page <= mvalid[lpn] ? map_rdata : '0;
        end
        pmft_pkg::EMIT_FRESH: begin
          dst_page  <= fresh_page;
          spare_tag <= pmft_pkg::LSN_W'(lpn);
        end
        pmft_pkg::EMIT_CAP: begin
          command <= pmft_pkg::CMD_CAPACITY;
        end
        pmft_pkg::EMIT_COPY: begin
          command  <= pmft_pkg::CMD_COPY;
          src_page <= copy_src;
          dst_page <= copy_dst;
          last     <= 1'b0;
        end
        pmft_pkg::EMIT_ERASE: begin
          command     <= pmft_pkg::CMD_ERASE;
          erase_block <= victim[PW-1:OW];
          last        <= 1'b0;
        end
        pmft_pkg::EMIT_FINAL: begin
          dst_page  <= final_page;
          spare_tag <= pmft_pkg::LSN_W'(lpn);
        end
        default: begin
          command <= pmft_pkg::CMD_PROGRAM;
        end
      endcase
    end
  end

endmodule

@@ rtl/pmft_ctrl.sv @@
// ----------------------------------------------------------------------------
// pmft_ctrl
// Controller: lookup, fresh program, capacity error and garbage collection.
// ----------------------------------------------------------------------------
module pmft_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pmft_pkg::sts_t  sts,
  output pmft_pkg::ctl_t  ctl
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOOK    = 3'd1;
  localparam logic [2:0] S_WAITH   = 3'd2;
  localparam logic [2:0] S_VICT    = 3'd3;
  localparam logic [2:0] S_COPYSEL = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.push   = sts.op;
        state_next = S_OUT;
        ret_next   = S_IDLE;
        if (!sts.op) begin
          ctl.emit = pmft_pkg::EMIT_LOOKUP;
        end else if (sts.fresh_left) begin
          ctl.emit = pmft_pkg::EMIT_FRESH;
        end else if (sts.fifo_empty_after) begin
          ctl.emit = pmft_pkg::EMIT_CAP;
        end else begin
          state_next = S_WAITH;
        end
      end
      S_WAITH: begin
        state_next = S_VICT;
      end
      S_VICT: begin
        ctl.load_victim = 1'b1;
        state_next      = S_COPYSEL;
      end
      S_COPYSEL: begin
        if (sts.i_done) begin
          ctl.emit   = pmft_pkg::EMIT_ERASE;
          state_next = S_OUT;
          ret_next   = S_FINISH;
        end else if (sts.i_victim) begin
          ctl.i_inc = 1'b1;
        end else begin
          ctl.emit     = pmft_pkg::EMIT_COPY;
          ctl.scan_clr = 1'b1;
          state_next   = S_OUT;
          ret_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          ctl.i_inc  = 1'b1;
          state_next = S_COPYSEL;
        end
      end
      S_FINISH: begin
        ctl.emit   = pmft_pkg::EMIT_FINAL;
        state_next = S_OUT;
        ret_next   = S_IDLE;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = ret;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

@@ rtl/page_mapped_flash_translation.sv @@
// ----------------------------------------------------------------------------
// page_mapped_flash_translation
// Page-level flash translation with invalid-page queue and garbage collection.
// ----------------------------------------------------------------------------
// The input channel takes one request item (operation, lsn) when in_valid is
// high and in_stall low; the output channel hands out result items the same
// way under out_valid and out_stall. One request is handled at a time:
// in_stall stays high from acceptance until the last result has been taken.
// A read, a fresh-page write and a capacity error each give one result, formed
// in state S_LOOK and shown in S_OUT after acceptance in S_IDLE. A write after
// the fresh pages are spent runs garbage collection: up to PAGES_PER_BLK-1
// copy items, an erase and a program. Each copy is followed by a reverse scan
// of the map memory, one entry per cycle, through the single read port of the
// map memory. While out_stall is high the result item is held and nothing
// advances. Reset clears the map valid bits, the counters and the queue, and
// makes the last block the spare; the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module page_mapped_flash_translation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [pmft_pkg::LSN_W-1:0]   lsn,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pmft_pkg::CMD_W-1:0]   command,
  output logic [pmft_pkg::PAGE_W-1:0]  src_page,
  output logic [pmft_pkg::PAGE_W-1:0]  dst_page,
  output logic [pmft_pkg::BLK_W-1:0]   erase_block,
  output logic [pmft_pkg::LSN_W-1:0]   spare_tag,
  output logic                         last
);

  pmft_pkg::ctl_t ctl;
  pmft_pkg::sts_t sts;

  pmft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
  );

  pmft_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .operation(operation), .lsn(lsn),
    .command(command), .src_page(src_page), .dst_page(dst_page),
    .erase_block(erase_block), .spare_tag(spare_tag), .last(last)
  );

endmodule

@@ rtl/pmft_checker.sv @@
// ----------------------------------------------------------------------------
// pmft_checker
// Port-level checks on the flash translation block, bound to its top level.
// ----------------------------------------------------------------------------
`include "page_mapped_flash_translation_defines.svh"

module pmft_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pmft_pkg::CMD_W-1:0]   command,
  input logic                         last
);

  `PMFT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `PMFT_ASSERT_NEXT(a_cmd_stable, out_valid && out_stall, $stable(command), "command changed while stalled")
  `PMFT_ASSERT_NOW(a_one_at_a_time, in_valid && !in_stall, !out_valid, "request taken while a result is pending")
  `PMFT_ASSERT_NOW(a_last_kind, out_valid && !last, command == pmft_pkg::CMD_COPY || command == pmft_pkg::CMD_ERASE, "non-final result of wrong kind")
  `PMFT_ASSERT_NOW(a_final_kind, out_valid && last, command != pmft_pkg::CMD_COPY && command != pmft_pkg::CMD_ERASE, "final result of wrong kind")

endmodule

bind page_mapped_flash_translation pmft_checker u_pmft_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .command(command), .last(last)
);
